/* design/scgu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgu_pkg
// Shared types, codes and helpers of the sparse constraint gap update block.
// ----------------------------------------------------------------------------
package scgu_pkg;

  // Default sizes
  localparam int NUM_VARS_DEF  = 1024;
  localparam int NUM_CONS_DEF  = 1024;
  localparam int MAX_TERMS_DEF = 16;

  // Port widths
  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 152;
  localparam int USER_W     = 2;
  localparam int CFG_W      = 16;
  localparam int TOTAL_W    = 11;
  localparam int CIDX_W     = 10;

  // Configuration register indexes
  localparam logic CFG_TABU_BASE = 1'b0;
  localparam logic CFG_TABU_VAR  = 1'b1;

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    FN_LOAD_TERM = 2'd0,
    FN_SET_GAP   = 2'd1,
    FN_MOVE      = 2'd2,
    FN_SET_VALUE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_FLIP      = 2'd0,
    KIND_MOVE_DONE = 2'd1,
    KIND_ACK       = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GAP_SET,
    ST_VAR_UPD,
    ST_T_ADDR,
    ST_T_CON,
    ST_T_MUL,
    ST_T_SUM,
    ST_T_NEG,
    ST_T_APPLY,
    ST_TABU,
    ST_FLIPS,
    ST_DONE,
    ST_ACK
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_TAKE,
    OP_GAP_SET,
    OP_VAR_UPD,
    OP_TERM_RD,
    OP_GAP_RD,
    OP_MUL,
    OP_SUM,
    OP_NEG,
    OP_APPLY,
    OP_TABU,
    OP_EMIT_FLIP,
    OP_EMIT_DONE,
    OP_EMIT_ACK
  } op_e;

  // Controller to datapath
  typedef struct packed {
    op_e op;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_e func;
    logic  v_ok;
    logic  c_ok;
    logic  clr_last;
    logic  cnt_zero;
    logic  term_last;
    logic  mod_done;
    logic  q_empty;
    logic  q_one;
    logic  out_free;
  } status_t;

  // A constraint is satisfied when its gap is zero or negative
  function automatic logic is_sat(input logic [63:0] g);
    return g[63] || (g == 64'd0);
  endfunction

endpackage

/* design/scgu_moddiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgu_moddiv
// Restoring remainder unit: 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module scgu_moddiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic [15:0] rem_o,
  output logic        done_o
);

  logic [31:0] quo_q;
  logic [15:0] rem_q, div_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [16:0] shifted;
  logic [16:0] diff;
  logic [15:0] rem_d;

  // One restoring step
  always_comb begin
    shifted = {rem_q, quo_q[31]};
    diff    = shifted - {1'b0, div_q};
    rem_d   = (shifted >= {1'b0, div_q}) ? diff[15:0] : shifted[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

/* design/scgu_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgu_ctrl
// Sequencer: clearing sweep, item decode, term walk and result emission.
// ----------------------------------------------------------------------------
module scgu_ctrl
  import scgu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (status_i.func)
            FN_SET_GAP: state_d = status_i.c_ok ? ST_GAP_SET : ST_ACK;
            FN_MOVE:    state_d = status_i.v_ok ? ST_VAR_UPD : ST_DONE;
            default:    state_d = ST_ACK;
          endcase
        end
      end
      ST_GAP_SET: state_d = ST_ACK;
      ST_VAR_UPD: state_d = status_i.cnt_zero ? ST_TABU : ST_T_ADDR;
      ST_T_ADDR:  state_d = ST_T_CON;
      ST_T_CON:   state_d = ST_T_MUL;
      ST_T_MUL:   state_d = ST_T_SUM;
      ST_T_SUM:   state_d = ST_T_NEG;
      ST_T_NEG:   state_d = ST_T_APPLY;
      ST_T_APPLY: state_d = status_i.term_last ? ST_TABU : ST_T_ADDR;
      ST_TABU: begin
        if (status_i.mod_done) state_d = status_i.q_empty ? ST_DONE : ST_FLIPS;
      end
      ST_FLIPS:   if (status_i.out_free && status_i.q_one) state_d = ST_DONE;
      ST_DONE:    if (status_i.out_free) state_d = ST_IDLE;
      ST_ACK:     if (status_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o.op      = OP_NONE;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_CLEAR:   cmd_o.op = OP_CLEAR;
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) cmd_o.op = OP_TAKE;
      end
      ST_GAP_SET: cmd_o.op = OP_GAP_SET;
      ST_VAR_UPD: cmd_o.op = OP_VAR_UPD;
      ST_T_ADDR:  cmd_o.op = OP_TERM_RD;
      ST_T_CON:   cmd_o.op = OP_GAP_RD;
      ST_T_MUL:   cmd_o.op = OP_MUL;
      ST_T_SUM:   cmd_o.op = OP_SUM;
      ST_T_NEG:   cmd_o.op = OP_NEG;
      ST_T_APPLY: cmd_o.op = OP_APPLY;
      ST_TABU:    if (status_i.mod_done) cmd_o.op = OP_TABU;
      ST_FLIPS:   if (status_i.out_free) cmd_o.op = OP_EMIT_FLIP;
      ST_DONE:    if (status_i.out_free) cmd_o.op = OP_EMIT_DONE;
      ST_ACK:     if (status_i.out_free) cmd_o.op = OP_EMIT_ACK;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

endmodule

/* design/scgu_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgu_datapath
// Memories, gap arithmetic, flip queue, tabu marks and the output register.
// ----------------------------------------------------------------------------
module scgu_datapath
  import scgu_pkg::*;
#(
  parameter int NUM_VARS          = NUM_VARS_DEF,
  parameter int NUM_CONS          = NUM_CONS_DEF,
  parameter int MAX_TERMS_PER_VAR = MAX_TERMS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [USER_W-1:0]     in_user_i,
  input  logic                  in_last_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic [USER_W-1:0]     out_user_o,
  output logic                  out_last_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o
);

  localparam int VAW    = $clog2(NUM_VARS);
  localparam int CAW    = $clog2(NUM_CONS);
  localparam int NTERMS = NUM_VARS * MAX_TERMS_PER_VAR;
  localparam int TAW    = $clog2(NTERMS);
  localparam int CNTW   = $clog2(MAX_TERMS_PER_VAR + 1);
  localparam int QD     = 2 ** CNTW;
  localparam int UCW    = $clog2(NUM_CONS);
  localparam int MAXN   = (NUM_VARS > NUM_CONS) ? NUM_VARS : NUM_CONS;
  localparam int CLRW   = $clog2(MAXN);

  // Input fields
  logic [9:0]  in_var;
  logic [3:0]  in_slot;
  logic [9:0]  in_con;
  logic [31:0] in_coef, in_step, in_rnd;
  logic [63:0] in_val;
  logic [31:0] in_var32, in_slot32, in_con32, in_tadr32;
  logic [VAW-1:0] in_vaddr;
  logic [CAW-1:0] in_caddr;
  logic [TAW-1:0] in_taddr;
  logic           in_v_ok, in_c_ok, in_s_ok;
  func_e          in_func;

  always_comb begin
    in_var    = in_data_i[9:0];
    in_slot   = in_data_i[13:10];
    in_con    = in_data_i[23:14];
    in_coef   = in_data_i[55:24];
    in_val    = in_data_i[119:56];
    in_step   = in_data_i[151:120];
    in_rnd    = in_data_i[183:152];
    in_func   = func_e'(in_user_i);
    in_var32  = 32'(in_var);
    in_slot32 = 32'(in_slot);
    in_con32  = 32'(in_con);
    in_vaddr  = in_var32[VAW-1:0];
    in_caddr  = in_con32[CAW-1:0];
    in_tadr32 = in_var32 * MAX_TERMS_PER_VAR + in_slot32;
    in_taddr  = in_tadr32[TAW-1:0];
    in_v_ok   = in_var32 < NUM_VARS;
    in_c_ok   = in_con32 < NUM_CONS;
    in_s_ok   = in_slot32 < MAX_TERMS_PER_VAR;
  end

  op_e op;
  assign op = cmd_i.op;

  // Configuration registers
  logic [CFG_W-1:0] tabu_base_q, tabu_var_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tabu_base_q <= 16'd3;
      tabu_var_q  <= 16'd10;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TABU_BASE) tabu_base_q <= cfg_wdata_i;
      if (cfg_idx_i == CFG_TABU_VAR)  tabu_var_q  <= cfg_wdata_i;
    end
  end

  // Clearing sweep counter
  logic [CLRW-1:0] clr_q;
  logic [31:0]     clr32;
  logic [VAW-1:0]  clr_vaddr;
  logic [CAW-1:0]  clr_caddr;
  logic            clr_v_ok, clr_c_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (op == OP_CLEAR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_comb begin
    clr32     = 32'(clr_q);
    clr_vaddr = clr32[VAW-1:0];
    clr_caddr = clr32[CAW-1:0];
    clr_v_ok  = clr32 < NUM_VARS;
    clr_c_ok  = clr32 < NUM_CONS;
  end

  // Item registers
  logic [VAW-1:0]  v_q;
  logic [CAW-1:0]  c_q;
  logic [63:0]     val_q, dmag_q;
  logic            dneg_q, inc_q;
  logic [31:0]     step_q;
  logic [TAW-1:0]  base_q;
  logic [31:0]     base32;

  assign base32 = in_var32 * MAX_TERMS_PER_VAR;

  always_ff @(posedge clk_i) begin
    if (op == OP_TAKE) begin
      v_q    <= in_vaddr;
      c_q    <= in_caddr;
      val_q  <= in_val;
      dneg_q <= in_val[63];
      dmag_q <= in_val[63] ? (~in_val + 64'd1) : in_val;
      inc_q  <= !in_val[63] && (in_val != 64'd0);
      step_q <= in_step;
      base_q <= base32[TAW-1:0];
    end
  end

  // Variable values
  logic [63:0] var_mem [NUM_VARS];
  logic [63:0] var_rd_q, var_sum, var_add;
  logic        var_ovf;

  always_comb begin
    var_add = var_rd_q + val_q;
    var_ovf = (var_rd_q[63] == val_q[63]) && (var_add[63] != var_rd_q[63]);
    var_sum = var_ovf ? (var_rd_q[63] ? SAT_MIN : SAT_MAX) : var_add;
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_CLEAR && clr_v_ok) begin
      var_mem[clr_vaddr] <= '0;
    end else if (op == OP_TAKE && in_func == FN_SET_VALUE && in_v_ok) begin
      var_mem[in_vaddr] <= in_val;
    end else if (op == OP_VAR_UPD) begin
      var_mem[v_q] <= var_sum;
    end
    if (op == OP_TAKE) var_rd_q <= var_mem[in_vaddr];
  end

  // Term counts
  logic [CNTW-1:0] cnt_mem [NUM_VARS];
  logic [CNTW-1:0] cnt_rd_q;
  logic [31:0]     slot_p1;

  assign slot_p1 = in_slot32 + 32'd1;

  always_ff @(posedge clk_i) begin
    if (op == OP_CLEAR && clr_v_ok) begin
      cnt_mem[clr_vaddr] <= '0;
    end else if (op == OP_TAKE && in_func == FN_LOAD_TERM && in_v_ok && in_s_ok &&
                 in_c_ok && in_last_i) begin
      cnt_mem[in_vaddr] <= slot_p1[CNTW-1:0];
    end
    if (op == OP_TAKE) cnt_rd_q <= cnt_mem[in_vaddr];
  end

  // Terms: constraint index and coefficient
  logic [CAW+31:0] term_mem [NTERMS];
  logic [CAW+31:0] term_rd_q;
  logic [CNTW-1:0] t_q, cnt_q;
  logic [31:0]     tadr32;
  logic [TAW-1:0]  taddr;

  always_comb begin
    tadr32 = 32'(base_q) + 32'(t_q);
    taddr  = tadr32[TAW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_TAKE && in_func == FN_LOAD_TERM && in_v_ok && in_s_ok && in_c_ok) begin
      term_mem[in_taddr] <= {in_caddr, in_coef};
    end
    if (op == OP_TERM_RD) term_rd_q <= term_mem[taddr];
  end

  // Gaps
  logic [63:0]    gap_mem [NUM_CONS];
  logic [63:0]    gap_rd_q, new_gap;
  logic [CAW-1:0] tcon_q, gap_raddr;
  logic [31:0]    cmag_q;
  logic           cneg_q;

  assign gap_raddr = (op == OP_TAKE) ? in_caddr : term_rd_q[CAW+31:32];

  always_ff @(posedge clk_i) begin
    if (op == OP_CLEAR && clr_c_ok) begin
      gap_mem[clr_caddr] <= '0;
    end else if (op == OP_GAP_SET) begin
      gap_mem[c_q] <= val_q;
    end else if (op == OP_APPLY) begin
      gap_mem[tcon_q] <= new_gap;
    end
    if (op == OP_TAKE || op == OP_GAP_RD) gap_rd_q <= gap_mem[gap_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_GAP_RD) begin
      tcon_q <= term_rd_q[CAW+31:32];
      cneg_q <= term_rd_q[31];
      cmag_q <= term_rd_q[31] ? (~term_rd_q[31:0] + 32'd1) : term_rd_q[31:0];
    end
  end

  // Product coefficient * delta in three registered steps
  logic [63:0]        p0_q, p1_q;
  logic               pneg_q;
  logic [95:0]        prod_q;
  logic signed [96:0] sp_q;
  logic signed [97:0] gsum;
  logic               gsum_ok;

  always_ff @(posedge clk_i) begin
    if (op == OP_MUL) begin
      p0_q   <= 64'(cmag_q) * 64'(dmag_q[31:0]);
      p1_q   <= 64'(cmag_q) * 64'(dmag_q[63:32]);
      pneg_q <= cneg_q ^ dneg_q;
    end
    if (op == OP_SUM) prod_q <= {32'd0, p0_q} + {p1_q, 32'd0};
    if (op == OP_NEG) sp_q <= pneg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
  end

  // Gap add and saturation
  always_comb begin
    gsum    = {sp_q[96], sp_q} + $signed({{34{gap_rd_q[63]}}, gap_rd_q});
    gsum_ok = (gsum[97:63] == '0) || (gsum[97:63] == '1);
    new_gap = gsum_ok ? gsum[63:0] : (gsum[97] ? SAT_MIN : SAT_MAX);
  end

  // Unsatisfied count and objective gap
  logic [UCW-1:0] unsat_q, unsat_flip;
  logic [63:0]    obj_q;
  logic           pre_sat, now_sat, flip;
  logic           set_old_un, set_new_un;

  always_comb begin
    pre_sat    = is_sat(gap_rd_q);
    now_sat    = is_sat(new_gap);
    flip       = (tcon_q != '0) && (pre_sat != now_sat);
    unsat_flip = now_sat ? (unsat_q - 1'b1) : (unsat_q + 1'b1);
    set_old_un = !is_sat(gap_rd_q);
    set_new_un = !is_sat(val_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unsat_q <= '0;
      obj_q   <= '0;
    end else if (op == OP_GAP_SET) begin
      if (c_q == '0) begin
        obj_q <= val_q;
      end else if (set_new_un && !set_old_un) begin
        unsat_q <= unsat_q + 1'b1;
      end else if (!set_new_un && set_old_un) begin
        unsat_q <= unsat_q - 1'b1;
      end
    end else if (op == OP_APPLY) begin
      if (tcon_q == '0) obj_q <= new_gap;
      if (flip) unsat_q <= unsat_flip;
    end
  end

  // Walk position and moved value
  logic [63:0] newval_q;

  always_ff @(posedge clk_i) begin
    if (op == OP_TAKE) begin
      newval_q <= '0;
    end else if (op == OP_VAR_UPD) begin
      newval_q <= var_sum;
      cnt_q    <= cnt_rd_q;
      t_q      <= '0;
    end else if (op == OP_APPLY) begin
      t_q <= t_q + 1'b1;
    end
  end

  // Flip queue, held until the move has finished
  logic [CAW-1:0]  qc_mem [QD];
  logic            qn_mem [QD];
  logic [UCW-1:0]  qt_mem [QD];
  logic [CNTW-1:0] qw_q, qr_q, qw_p1, qr_p1;

  assign qw_p1 = qw_q + 1'b1;
  assign qr_p1 = qr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qw_q <= '0;
      qr_q <= '0;
    end else if (op == OP_TAKE) begin
      qw_q <= '0;
      qr_q <= '0;
    end else begin
      if (op == OP_APPLY && flip) qw_q <= qw_p1;
      if (op == OP_EMIT_FLIP)     qr_q <= qr_p1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_APPLY && flip) begin
      qc_mem[qw_q] <= tcon_q;
      qn_mem[qw_q] <= !now_sat;
      qt_mem[qw_q] <= unsat_flip;
    end
  end

  // Tabu tenure remainder
  logic [15:0] div_rem;
  logic        div_done;

  scgu_moddiv u_moddiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op == OP_TAKE),
    .dividend_i (in_rnd),
    .divisor_i  ((tabu_var_q == '0) ? 16'd1 : tabu_var_q),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // Tabu marks: {last step, allowed step}
  logic [63:0] tinc_mem [NUM_VARS];
  logic [63:0] tdec_mem [NUM_VARS];
  logic [31:0] mark;

  assign mark = step_q + 32'(tabu_base_q) + 32'(div_rem);

  always_ff @(posedge clk_i) begin
    if (op == OP_CLEAR && clr_v_ok) begin
      tinc_mem[clr_vaddr] <= '0;
      tdec_mem[clr_vaddr] <= '0;
    end else if (op == OP_TABU) begin
      if (inc_q) tinc_mem[v_q] <= {step_q, mark};
      else       tdec_mem[v_q] <= {step_q, mark};
    end
  end

  // Output register
  logic        out_valid_q, out_last_q, out_nu_q, out_load;
  kind_e       out_kind_q;
  logic [9:0]  out_con_q;
  logic [10:0] out_tot_q;
  logic [63:0] out_obj_q, out_new_q;
  logic [31:0] u32, qt32, qc32;

  always_comb begin
    u32      = 32'(unsat_q);
    qt32     = 32'(qt_mem[qr_q]);
    qc32     = 32'(qc_mem[qr_q]);
    out_load = (op == OP_EMIT_FLIP) || (op == OP_EMIT_DONE) || (op == OP_EMIT_ACK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_obj_q <= obj_q;
      out_new_q <= newval_q;
      if (op == OP_EMIT_FLIP) begin
        out_kind_q <= KIND_FLIP;
        out_con_q  <= qc32[9:0];
        out_nu_q   <= qn_mem[qr_q];
        out_tot_q  <= qt32[10:0];
        out_last_q <= 1'b0;
      end else begin
        out_kind_q <= (op == OP_EMIT_DONE) ? KIND_MOVE_DONE : KIND_ACK;
        out_con_q  <= '0;
        out_nu_q   <= 1'b0;
        out_tot_q  <= u32[10:0];
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {2'b00, out_new_q, out_obj_q, out_tot_q, out_nu_q, out_con_q};
  assign out_user_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  // Status
  always_comb begin
    status_o.func      = in_func;
    status_o.v_ok      = in_v_ok;
    status_o.c_ok      = in_c_ok;
    status_o.clr_last  = (clr32 == MAXN - 1);
    status_o.cnt_zero  = (cnt_rd_q == '0);
    status_o.term_last = ((32'(t_q) + 32'd1) == 32'(cnt_q));
    status_o.mod_done  = div_done;
    status_o.q_empty   = (qr_q == qw_q);
    status_o.q_one     = (qr_p1 == qw_q);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Count of unsatisfied rows stays below the number of rows
  a_unsat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(unsat_q) < NUM_CONS)
    else $error("unsatisfied count out of range");

  // A flip is never pushed into a full queue
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_APPLY && flip) |-> (32'(qw_q) < MAX_TERMS_PER_VAR))
    else $error("flip queue overflow");

  // A result is only loaded when the output stage is free
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // The tabu update waits for the remainder unit
  a_tabu_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_TABU) |-> div_done)
    else $error("tabu mark taken before remainder ready");

endmodule

/* design/sparse_constraint_gap_update.sv */
`timescale 1ns / 1ps
// An acknowledged load or set value goes to the acknowledge state, and a set gap first writes
// its gap; a move writes the new variable value, then walks its terms (read term, read gap,
// two multiply steps, negate, write back), waits for the tenure remainder unit and emits
// its results in turn as the output register frees; one item is in work at a time.
// Reset: asynchronous, active low; a clearing pass over max(NUM_VARS, NUM_CONS) addresses
// then zeroes values, counts, gaps and tabu marks before the first transfer is taken.
// ----------------------------------------------------------------------------
// sparse_constraint_gap_update
// Incremental constraint gap update for local search over a sparse matrix.
// ----------------------------------------------------------------------------
module sparse_constraint_gap_update
  import scgu_pkg::*;
#(
  parameter int NUM_VARS          = NUM_VARS_DEF,
  parameter int NUM_CONS          = NUM_CONS_DEF,
  parameter int MAX_TERMS_PER_VAR = MAX_TERMS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // var_index, term_slot, con_index, coefficient, value, step, random_word
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [USER_W-1:0]     s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // flip_con_index, now_unsat, unsat_total, objective_gap, new_var_value, pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // kind
  output logic [USER_W-1:0]     m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  scgu_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  scgu_datapath #(
    .NUM_VARS          (NUM_VARS),
    .NUM_CONS          (NUM_CONS),
    .MAX_TERMS_PER_VAR (MAX_TERMS_PER_VAR)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* verif/tb_sparse_constraint_gap_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_constraint_gap_update
// Self-checking bench for the sparse constraint gap update block. Term lists,
// gaps and values are loaded, then moves are applied. A local copy of the
// matrix, gaps and unsatisfied flags predicts every flip, move-done and
// acknowledge transfer. Both stream sides idle at random, and the tabu
// registers are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_sparse_constraint_gap_update;
  import scgu_pkg::*;

  typedef struct {
    func_e              func;
    logic [9:0]         var_idx;
    logic [3:0]         slot;
    logic [9:0]         con;
    logic signed [31:0] coef;
    logic signed [63:0] val;
    logic [31:0]        step;
    logic [31:0]        rnd;
    logic               last_term;
  } gap_item_t;

  typedef struct {
    kind_e       kind;
    logic [9:0]  con;
    logic        unsat;
    logic [10:0] total;
    logic [63:0] obj;
    logic [63:0] newval;
    logic        last;
  } gap_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [USER_W-1:0]     s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [USER_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_idx_i = CFG_TABU_BASE;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;

  sparse_constraint_gap_update uut (.*);

  always #5 clk_i = ~clk_i;

  // Predicted block state
  logic signed [63:0] var_value [1024];
  logic [4:0]         term_count [1024];
  logic [9:0]         term_con [16384];
  logic signed [31:0] term_coef [16384];
  logic signed [63:0] con_gap [1024];
  logic               con_unsat [1024];
  logic [10:0]        unsat_count;

  // Slots written so far, per variable, so moves never read an unloaded term
  logic [15:0] slot_written [1024];

  gap_item_t   pending_items [$];
  gap_result_t expected_results [$];
  gap_item_t   cur_item;

  bit idle_en = 1'b1;
  bit hold_send = 1'b0;
  int stall_requests = 0;
  int error_count = 0;

  function automatic logic gap_sat(input logic [63:0] g);
    return g[63] || (g == 64'd0);
  endfunction

  function automatic logic [63:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SAT_MIN : SAT_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] gap_after(input logic signed [63:0] g,
                                            input logic signed [31:0] cf,
                                            input logic signed [63:0] d);
    logic signed [127:0] ce, de, ge, s;
    ce = cf;
    de = d;
    ge = g;
    s = ce * de + ge;
    if (s > $signed({64'd0, SAT_MAX})) return SAT_MAX;
    if (s < $signed({{64{1'b1}}, SAT_MIN})) return SAT_MIN;
    return s[63:0];
  endfunction

  function automatic void mark_con(input int c, input logic unsat);
    if (unsat && !con_unsat[c]) unsat_count++;
    else if (!unsat && con_unsat[c]) unsat_count--;
    con_unsat[c] = unsat;
  endfunction

  // Work out the results of one accepted item and update the local state
  function automatic void predict_gap_update(input gap_item_t it);
    gap_result_t flips [$];
    gap_result_t r;
    logic [63:0] newval;
    logic [63:0] ng;
    int pos;
    int ci;
    newval = '0;
    case (it.func)
      FN_LOAD_TERM: begin
        pos = it.var_idx * 16 + it.slot;
        term_con[pos] = it.con;
        term_coef[pos] = it.coef;
        if (it.last_term) term_count[it.var_idx] = 5'(it.slot + 1);
      end
      FN_SET_GAP: begin
        con_gap[it.con] = it.val;
        if (it.con != 0) mark_con(it.con, !gap_sat(it.val));
      end
      FN_SET_VALUE: var_value[it.var_idx] = it.val;
      default: begin
        var_value[it.var_idx] = sat_add(var_value[it.var_idx], it.val);
        newval = var_value[it.var_idx];
        for (int t = 0; t < term_count[it.var_idx]; t++) begin
          pos = it.var_idx * 16 + t;
          ci = term_con[pos];
          ng = gap_after(con_gap[ci], term_coef[pos], it.val);
          if (ci != 0 && gap_sat(con_gap[ci]) != gap_sat(ng)) begin
            mark_con(ci, !gap_sat(ng));
            r.kind = KIND_FLIP;
            r.con = 10'(ci);
            r.unsat = !gap_sat(ng);
            r.total = unsat_count;
            r.last = 1'b0;
            flips.push_back(r);
          end
          con_gap[ci] = ng;
        end
      end
    endcase
    // Flip results carry the objective gap after the whole move
    foreach (flips[k]) begin
      flips[k].obj = con_gap[0];
      flips[k].newval = newval;
      expected_results.push_back(flips[k]);
    end
    r.kind = (it.func == FN_MOVE) ? KIND_MOVE_DONE : KIND_ACK;
    r.con = '0;
    r.unsat = 1'b0;
    r.total = unsat_count;
    r.obj = con_gap[0];
    r.newval = newval;
    r.last = 1'b1;
    expected_results.push_back(r);
  endfunction

  // Input driver
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      s_axis_tlast <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_gap_update(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_send) begin
          cur_item = pending_items.pop_front();
          s_axis_tdata <= {cur_item.rnd, cur_item.step, cur_item.val, cur_item.coef,
                           cur_item.con, cur_item.slot, cur_item.var_idx};
          s_axis_tuser <= cur_item.func;
          s_axis_tlast <= cur_item.last_term;
          s_axis_tvalid <= 1'b1;
          if (idle_en && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 11);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls plus long hold-offs on request
  int recv_gap;
  int long_left;
  int stalls_served;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap <= 0;
      long_left <= 0;
      stalls_served <= 0;
    end else if (stall_requests != stalls_served) begin
      stalls_served <= stall_requests;
      long_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_en && $urandom_range(0, 3) == 0) recv_gap <= $urandom_range(1, 11);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    gap_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: kind %0d", m_axis_tuser);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (m_axis_tuser !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[9:0] !== e.con) begin
          $error("flip_con_index: expected %0d, got %0d", e.con, m_axis_tdata[9:0]);
          error_count++;
        end
        if (m_axis_tdata[10] !== e.unsat) begin
          $error("now_unsat: expected %0d, got %0d", e.unsat, m_axis_tdata[10]);
          error_count++;
        end
        if (m_axis_tdata[21:11] !== e.total) begin
          $error("unsat_total: expected %0d, got %0d", e.total, m_axis_tdata[21:11]);
          error_count++;
        end
        if (m_axis_tdata[85:22] !== e.obj) begin
          $error("objective_gap: expected %0d, got %0d", $signed(e.obj),
                 $signed(m_axis_tdata[85:22]));
          error_count++;
        end
        if (m_axis_tdata[149:86] !== e.newval) begin
          $error("new_var_value: expected %0d, got %0d", $signed(e.newval),
                 $signed(m_axis_tdata[149:86]));
          error_count++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  task automatic add_item(input func_e f, input int v, input int s, input int c,
                          input logic signed [31:0] cf, input logic signed [63:0] val,
                          input logic lt);
    gap_item_t it;
    it.func = f;
    it.var_idx = 10'(v);
    it.slot = 4'(s);
    it.con = 10'(c);
    it.coef = cf;
    it.val = val;
    it.step = $urandom;
    it.rnd = $urandom;
    it.last_term = lt;
    pending_items.push_back(it);
  endtask

  task automatic add_load(input int v, input int s, input int c,
                          input logic signed [31:0] cf, input logic lt);
    slot_written[v][s] = 1'b1;
    add_item(FN_LOAD_TERM, v, s, c, cf, {$urandom, $urandom}, lt);
  endtask

  function automatic int pick_var();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return r % 8;
    if (r < 18) return 1023;
    return $urandom_range(0, 1023);
  endfunction

  function automatic int pick_con();
    int r;
    r = $urandom_range(0, 19);
    if (r < 17) return $urandom_range(0, 15);
    if (r == 17) return 1023;
    return $urandom_range(0, 1023);
  endfunction

  function automatic logic [63:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 64'(int'($urandom_range(0, 40)) - 20);
    if (r < 95) return {$urandom, $urandom};
    if (r < 97) return SAT_MAX;
    if (r < 99) return SAT_MIN;
    return 64'd0;
  endfunction

  function automatic logic [31:0] pick_coef();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 10) - 5;
  endfunction

  // Mostly term lists and moves over a small set of variables and constraints
  task automatic add_random(input int n);
    int made;
    int r;
    int v;
    int s;
    int len;
    int mask;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      v = pick_var();
      if (r < 15) begin
        len = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) add_load(v, k, pick_con(), pick_coef(), k == len - 1);
        made += len;
      end else if (r < 30) begin
        add_item(FN_SET_GAP, $urandom_range(0, 1023), $urandom_range(0, 15), pick_con(),
                 $urandom, pick_value(), 1'($urandom_range(0, 1)));
        made++;
      end else if (r < 35) begin
        add_item(FN_SET_VALUE, v, $urandom_range(0, 15), $urandom_range(0, 1023), $urandom,
                 pick_value(), 1'($urandom_range(0, 1)));
        made++;
      end else if (r < 40) begin
        // stray load; it only sets the count if every lower slot holds a term
        v = $urandom_range(0, 1023);
        s = $urandom_range(0, 15);
        mask = (2 << s) - 1;
        slot_written[v][s] = 1'b1;
        add_load(v, s, pick_con(), pick_coef(),
                 $urandom_range(0, 1) && ((int'(slot_written[v]) & mask) == mask));
        made++;
      end else begin
        add_item(FN_MOVE, v, $urandom_range(0, 15), $urandom_range(0, 1023), $urandom,
                 pick_value(), 1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stimulus sequencing
  initial begin
    foreach (var_value[i]) begin
      var_value[i] = '0;
      term_count[i] = '0;
      slot_written[i] = '0;
      con_gap[i] = '0;
      con_unsat[i] = 1'b0;
    end
    unsat_count = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme coefficients, saturation, zero delta, empty term lists
    write_reg(CFG_TABU_BASE, 16'd0);
    write_reg(CFG_TABU_VAR, 16'd1);
    add_load(1, 0, 0, 32'sd1, 1'b0);
    add_load(1, 1, 1, 32'sh7FFF_FFFF, 1'b0);
    add_load(1, 2, 1023, 32'sh8000_0000, 1'b0);
    add_load(1, 3, 2, -32'sd1, 1'b1);
    add_item(FN_SET_GAP, 0, 0, 1, 0, -64'sd5, 1'b0);
    add_item(FN_SET_GAP, 0, 0, 1023, 0, 64'sd0, 1'b0);
    add_item(FN_SET_GAP, 0, 0, 2, 0, 64'sd10, 1'b0);
    add_item(FN_SET_GAP, 0, 0, 0, 0, -64'sd7, 1'b0);
    add_item(FN_SET_VALUE, 1, 0, 0, 0, SAT_MAX, 1'b0);
    add_item(FN_MOVE, 1, 0, 0, 0, 64'sd1, 1'b0);
    add_item(FN_MOVE, 1, 0, 0, 0, 64'sd0, 1'b0);
    add_item(FN_MOVE, 1, 0, 0, 0, SAT_MIN, 1'b1);
    add_item(FN_MOVE, 1, 0, 0, 0, SAT_MAX, 1'b0);
    add_item(FN_MOVE, 1, 0, 0, 0, -64'sd3, 1'b0);
    add_item(FN_MOVE, 0, 15, 1023, -1, 64'sd5, 1'b1);
    add_item(FN_MOVE, 1023, 0, 0, 0, -64'sd1, 1'b0);
    add_item(FN_SET_GAP, 1023, 15, 1023, 0, SAT_MAX, 1'b1);
    add_item(FN_SET_GAP, 0, 0, 1023, 0, SAT_MIN, 1'b0);
    add_item(FN_SET_VALUE, 1023, 15, 0, 0, SAT_MIN, 1'b1);
    wait_idle();

    // Long receiver hold-off fills the block; then a sender pause mid-phase
    write_reg(CFG_TABU_BASE, 16'hFFFF);
    write_reg(CFG_TABU_VAR, 16'hFFFF);
    stall_requests++;
    add_random(35);
    while (pending_items.size() > 0) @(negedge clk_i);
    hold_send = 1'b1;
    while (s_axis_tvalid || expected_results.size() > 0) @(negedge clk_i);
    hold_send = 1'b0;
    add_random(35);
    wait_idle();

    // Zero variation
    write_reg(CFG_TABU_BASE, 16'd17);
    write_reg(CFG_TABU_VAR, 16'd0);
    add_random(50);
    wait_idle();

    // Final stretch at full rate
    idle_en = 1'b0;
    write_reg(CFG_TABU_VAR, 16'd10);
    add_random(60);
    wait_idle();
    repeat (50) @(negedge clk_i);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
